### src/ccs_pkg.sv
// shared types and constants of the crimper cylinder sequencer
package ccs_pkg;

   localparam int TIME_W    = 16;
   localparam int ELAPSED_W = 17;
   localparam int CSR_IDX_W = 3;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_CONFIRM_TIME    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INSERT_ON_TIME  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INSERT_OFF_TIME = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_ON_TIME   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLDOFF_TIME    = 3'd4;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_START = 2'd1,
      OP_STOP  = 2'd2
   } opcode_type;

   typedef enum logic [2:0] {
      PH_WAIT      = 3'd0,
      PH_CONFIRM   = 3'd1,
      PH_INS_ON    = 3'd2,
      PH_INS_OFF   = 3'd3,
      PH_PRESS_ON  = 3'd4,
      PH_PRESS_OFF = 3'd5,
      PH_REMOVED   = 3'd6,
      PH_INACTIVE  = 3'd7
   } phase_type;

   typedef struct packed {
      logic [TIME_W-1:0] confirm_time;
      logic [TIME_W-1:0] insert_on_time;
      logic [TIME_W-1:0] insert_off_time;
      logic [TIME_W-1:0] press_on_time;
      logic [TIME_W-1:0] removal_holdoff_time;
   } cfg_type;

   typedef struct packed {
      phase_type phase;
      logic      insert_valve;
      logic      main_valve;
   } result_type;

endpackage

### src/ccs_channel_if.sv
// request and response channel interfaces of the crimper cylinder sequencer
interface ccs_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic       sensor_level;

   modport source (output valid, output opcode, output sensor_level, input ready);
   modport sink   (input valid, input opcode, input sensor_level, output ready);
endinterface

interface ccs_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] state_code;
   logic       insert_valve;
   logic       main_valve;

   modport source (output valid, output state_code, output insert_valve,
                   output main_valve, input ready);
   modport sink   (input valid, input state_code, input insert_valve,
                   input main_valve, output ready);
endinterface

### src/crimper_cylinder_sequencer_core.sv
// top level of the crimper cylinder sequencer
// an accepted request item passes through the input register, then the response register
// throughput: one item per cycle while the response side keeps taking items; the
//   phase update is combinational between the input and response registers
// reset: synchronous, active high; phase inactive, tick count and valves
//   cleared, timing registers zero, both channels empty
module crimper_cylinder_sequencer_core (
   input  logic                            clock,
   input  logic                            reset,
   ccs_req_if.sink                         req_if,
   ccs_rsp_if.source                       rsp_if,
   input  logic                            csr_write_enable,
   input  logic [ccs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ccs_pkg::TIME_W-1:0]      csr_write_data
);
   import ccs_pkg::*;

   // input register
   logic        in_valid_ff;
   logic [1:0]  in_opcode_ff;
   logic        in_sensor_ff;

   // response register
   logic        out_valid_ff;
   result_type  out_ff;

   cfg_type     cfg;
   result_type  nxt;
   logic        advance;
   logic        req_accept;

   // the held item moves on when the response slot is free or being emptied
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;
   assign req_accept = req_if.valid && req_if.ready;

   ccs_config_regs u_config (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // phase state commits only when the item moves into the response slot
   ccs_phase_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .opcode       (in_opcode_ff),
      .sensor_level (in_sensor_ff),
      .cfg          (cfg),
      .nxt          (nxt)
   );

   // input register control
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   // input payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_opcode_ff <= req_if.opcode;
         in_sensor_ff <= req_if.sensor_level;
      end
   end

   // response register control
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= nxt;
      end
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.state_code   = out_ff.phase;
   assign rsp_if.insert_valve = out_ff.insert_valve;
   assign rsp_if.main_valve   = out_ff.main_valve;

   // a held item that cannot move on must still be held next cycle
   a_hold_item: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("held request item dropped");

   // a stop always shows inactive in its response
   a_stop_inactive: assert property (@(posedge clock) disable iff (reset)
      advance && (in_opcode_ff == OP_STOP) |=> rsp_if.state_code == PH_INACTIVE)
      else $error("stop did not reach inactive");

   // a start always shows wait in its response
   a_start_wait: assert property (@(posedge clock) disable iff (reset)
      advance && (in_opcode_ff == OP_START) |=> rsp_if.state_code == PH_WAIT)
      else $error("start did not reach wait");

endmodule

### src/ccs_config_regs.sv
// configuration registers of the crimper cylinder sequencer
module ccs_config_regs (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [ccs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ccs_pkg::TIME_W-1:0]      csr_write_data,
   output ccs_pkg::cfg_type                cfg
);
   import ccs_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_CONFIRM_TIME:    cfg_in.confirm_time         = csr_write_data;
            CSR_INSERT_ON_TIME:  cfg_in.insert_on_time       = csr_write_data;
            CSR_INSERT_OFF_TIME: cfg_in.insert_off_time      = csr_write_data;
            CSR_PRESS_ON_TIME:   cfg_in.press_on_time        = csr_write_data;
            CSR_HOLDOFF_TIME:    cfg_in.removal_holdoff_time = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### src/ccs_phase_engine.sv
// phase sequencer state and next-state logic
module ccs_phase_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [1:0]           opcode,
   input  logic                 sensor_level,
   input  ccs_pkg::cfg_type     cfg,
   output ccs_pkg::result_type  nxt
);
   import ccs_pkg::*;

   phase_type              phase_ff, phase_in;
   logic [ELAPSED_W-1:0]   elapsed_ff, elapsed_in, elapsed_inc;
   logic                   insert_ff, insert_in;
   logic                   press_ff, press_in;
   logic                   present;

   // saturating tick count
   assign elapsed_inc = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 1'b1;
   assign present     = ~sensor_level;

   always_comb begin
      phase_in   = phase_ff;
      elapsed_in = elapsed_ff;
      insert_in  = insert_ff;
      press_in   = press_ff;
      case (opcode)
         OP_TICK: begin
            elapsed_in = elapsed_inc;
            case (phase_ff)
               PH_WAIT: begin
                  if (present) begin
                     phase_in   = PH_CONFIRM;
                     elapsed_in = '0;
                  end
               end
               PH_CONFIRM: begin
                  if (!present) begin
                     phase_in   = PH_WAIT;
                     elapsed_in = '0;
                  end else if (elapsed_inc > {1'b0, cfg.confirm_time}) begin
                     insert_in  = 1'b1;
                     phase_in   = PH_INS_ON;
                     elapsed_in = '0;
                  end
               end
               PH_INS_ON: begin
                  if (elapsed_inc > {1'b0, cfg.insert_on_time}) begin
                     insert_in  = 1'b0;
                     phase_in   = PH_INS_OFF;
                     elapsed_in = '0;
                  end
               end
               PH_INS_OFF: begin
                  if (elapsed_inc > {1'b0, cfg.insert_off_time}) begin
                     press_in   = 1'b1;
                     phase_in   = PH_PRESS_ON;
                     elapsed_in = '0;
                  end
               end
               PH_PRESS_ON: begin
                  if (elapsed_inc > {1'b0, cfg.press_on_time}) begin
                     press_in   = 1'b0;
                     phase_in   = PH_PRESS_OFF;
                     elapsed_in = '0;
                  end
               end
               PH_PRESS_OFF: begin
                  // part pulled out once the sensor reads high
                  if (sensor_level) begin
                     phase_in   = PH_REMOVED;
                     elapsed_in = '0;
                  end
               end
               PH_REMOVED: begin
                  if (elapsed_inc > {1'b0, cfg.removal_holdoff_time}) begin
                     phase_in   = PH_WAIT;
                     elapsed_in = '0;
                  end
               end
               default: begin
                  // inactive re-enters itself on every tick
                  phase_in   = PH_INACTIVE;
                  elapsed_in = '0;
               end
            endcase
         end
         OP_START: begin
            phase_in   = PH_WAIT;
            elapsed_in = '0;
         end
         OP_STOP: begin
            phase_in   = PH_INACTIVE;
            elapsed_in = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_INACTIVE;
         elapsed_ff <= '0;
         insert_ff  <= 1'b0;
         press_ff   <= 1'b0;
      end else if (step) begin
         phase_ff   <= phase_in;
         elapsed_ff <= elapsed_in;
         insert_ff  <= insert_in;
         press_ff   <= press_in;
      end
   end

   assign nxt.phase        = phase_in;
   assign nxt.insert_valve = insert_in;
   assign nxt.main_valve   = press_in;

endmodule

### tb/tb_crimper_cylinder_sequencer_core.sv
// self-checking testbench of the crimper cylinder sequencer core
`timescale 1ns / 100ps

module tb_crimper_cylinder_sequencer_core;
   import ccs_pkg::*;

   // opcode with no function and register indexes past the last timer
   localparam logic [1:0]           OP_UNUSED     = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO  = CSR_HOLDOFF_TIME + 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI  = '1;
   localparam logic [TIME_W-1:0]    TIME_MAX      = '1;
   localparam logic [ELAPSED_W-1:0] ELAPSED_LIMIT = '1;
   localparam int                   LONG_HOLD     = 300;

   typedef struct {
      logic [1:0] opcode;
      logic       sensor_level;
   } crimp_cmd_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [TIME_W-1:0]    csr_write_data;

   ccs_req_if req_ch ();
   ccs_rsp_if rsp_ch ();

   crimper_cylinder_sequencer_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_ch),
      .rsp_if           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // sequencer state as the block should hold it
   cfg_type                timing_cfg   = '0;
   phase_type              seq_phase    = PH_INACTIVE;
   logic [ELAPSED_W-1:0]   seq_elapsed  = '0;
   logic                   seq_insert   = 1'b0;
   logic                   seq_press    = 1'b0;

   crimp_cmd_type          pending_cmds[$];
   result_type             expected_status[$];
   logic                   req_taken      = 1'b0;
   int unsigned            send_idle_pct  = 0;
   int unsigned            recv_idle_pct  = 0;
   int                     rsp_hold_cycles = 0;
   int unsigned            mismatch_count = 0;
   int unsigned            queued_items;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   function automatic void move_to(phase_type next);
      seq_phase   = next;
      seq_elapsed = '0;
   endfunction

   // next state and outputs for one command
   function automatic result_type advance_sequencer(logic [1:0] op, logic sensor);
      result_type r;
      logic       present;
      present = !sensor;
      case (op)
         OP_TICK: begin
            if (seq_elapsed != ELAPSED_LIMIT) seq_elapsed++;
            case (seq_phase)
               PH_WAIT: if (present) move_to(PH_CONFIRM);
               PH_CONFIRM: begin
                  if (!present) move_to(PH_WAIT);
                  else if (seq_elapsed > timing_cfg.confirm_time) begin
                     seq_insert = 1'b1;
                     move_to(PH_INS_ON);
                  end
               end
               PH_INS_ON: begin
                  if (seq_elapsed > timing_cfg.insert_on_time) begin
                     seq_insert = 1'b0;
                     move_to(PH_INS_OFF);
                  end
               end
               PH_INS_OFF: begin
                  if (seq_elapsed > timing_cfg.insert_off_time) begin
                     seq_press = 1'b1;
                     move_to(PH_PRESS_ON);
                  end
               end
               PH_PRESS_ON: begin
                  if (seq_elapsed > timing_cfg.press_on_time) begin
                     seq_press = 1'b0;
                     move_to(PH_PRESS_OFF);
                  end
               end
               PH_PRESS_OFF: if (!present) move_to(PH_REMOVED);
               PH_REMOVED: begin
                  if (seq_elapsed > timing_cfg.removal_holdoff_time) move_to(PH_WAIT);
               end
               default: move_to(PH_INACTIVE);
            endcase
         end
         OP_START: move_to(PH_WAIT);
         OP_STOP:  move_to(PH_INACTIVE);
         default: ;
      endcase
      r.phase        = seq_phase;
      r.insert_valve = seq_insert;
      r.main_valve   = seq_press;
      return r;
   endfunction

   task automatic flag_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   // input side: new item only once the current one is taken
   always @(negedge clock) begin : driver
      crimp_cmd_type cmd;
      if (!reset && (!req_ch.valid || req_taken)) begin
         if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            cmd = pending_cmds.pop_front();
            req_ch.valid        <= 1'b1;
            req_ch.opcode       <= cmd.opcode;
            req_ch.sensor_level <= cmd.sensor_level;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // output side: random stalls, or a long hold-off when one is requested
   always @(negedge clock) begin : receiver
      if (rsp_hold_cycles > 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_hold_cycles--;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // responses are checked before the item taken on the same edge is predicted
   always @(posedge clock) begin : monitor
      result_type want;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_status.size() == 0) begin
               flag_mismatch($sformatf("item with nothing pending, state %0d",
                                       rsp_ch.state_code));
            end else begin
               want = expected_status.pop_front();
               if (rsp_ch.state_code !== want.phase)
                  flag_mismatch($sformatf("state %0d, want %0d",
                                          rsp_ch.state_code, want.phase));
               if (rsp_ch.insert_valve !== want.insert_valve)
                  flag_mismatch($sformatf("insert valve %b, want %b",
                                          rsp_ch.insert_valve, want.insert_valve));
               if (rsp_ch.main_valve !== want.main_valve)
                  flag_mismatch($sformatf("main valve %b, want %b",
                                          rsp_ch.main_valve, want.main_valve));
            end
         end
         req_taken = req_ch.valid && req_ch.ready;
         if (req_taken)
            expected_status.push_back(advance_sequencer(req_ch.opcode,
                                                        req_ch.sensor_level));
      end
   end

   task automatic add_cmd(logic [1:0] op, logic sensor);
      crimp_cmd_type cmd;
      cmd.opcode       = op;
      cmd.sensor_level = sensor;
      pending_cmds.push_back(cmd);
      if (op != OP_UNUSED) queued_items++;
   endtask

   // block idle: everything sent and every response back
   task automatic wait_drained();
      do begin
         @(posedge clock);
         #1;
      end while (pending_cmds.size() != 0 || req_ch.valid || expected_status.size() != 0);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [TIME_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_CONFIRM_TIME:    timing_cfg.confirm_time         = value;
         CSR_INSERT_ON_TIME:  timing_cfg.insert_on_time       = value;
         CSR_INSERT_OFF_TIME: timing_cfg.insert_off_time      = value;
         CSR_PRESS_ON_TIME:   timing_cfg.press_on_time        = value;
         CSR_HOLDOFF_TIME:    timing_cfg.removal_holdoff_time = value;
         default: ;
      endcase
   endtask

   task automatic program_timing(int unsigned hi);
      write_csr(CSR_CONFIRM_TIME,    TIME_W'($urandom_range(hi)));
      write_csr(CSR_INSERT_ON_TIME,  TIME_W'($urandom_range(hi)));
      write_csr(CSR_INSERT_OFF_TIME, TIME_W'($urandom_range(hi)));
      write_csr(CSR_PRESS_ON_TIME,   TIME_W'($urandom_range(hi)));
      write_csr(CSR_HOLDOFF_TIME,    TIME_W'($urandom_range(hi)));
      write_csr(CSR_SPARE_LO + CSR_IDX_W'($urandom_range(2)), TIME_W'($urandom));
   endtask

   // mostly complete part cycles: part placed, held, pulled; some noise in between
   task automatic queue_part_cycles(int unsigned count);
      int  span;
      int  low_run;
      int  high_run;
      int  burst;
      bit  rearm;
      logic [1:0] op;
      span = int'(timing_cfg.confirm_time) + int'(timing_cfg.insert_on_time) +
             int'(timing_cfg.insert_off_time) + int'(timing_cfg.press_on_time) + 4;
      rearm = 1'b1;
      queued_items = 0;
      while (queued_items < count) begin
         if ($urandom_range(99) < 12) begin
            burst = $urandom_range(1, 4);
            repeat (burst) begin
               op = 2'($urandom_range(3));
               add_cmd(op, 1'($urandom_range(1)));
               if (op == OP_STOP) rearm = 1'b1;
            end
         end else begin
            if (rearm || $urandom_range(99) < 15) add_cmd(OP_START, 1'($urandom_range(1)));
            rearm = 1'b0;
            // a short hold breaks the sequence partway
            if ($urandom_range(99) < 70) low_run = span + $urandom_range(4);
            else low_run = $urandom_range(span);
            high_run = $urandom_range(1, int'(timing_cfg.removal_holdoff_time) + 4);
            repeat (low_run) add_cmd(OP_TICK, 1'b0);
            repeat (high_run) add_cmd(OP_TICK, 1'b1);
         end
      end
   endtask

   initial begin : stimulus
      req_ch.valid        = 1'b0;
      req_ch.opcode       = OP_TICK;
      req_ch.sensor_level = 1'b1;
      rsp_ch.ready        = 1'b0;
      csr_write_enable    = 1'b0;
      csr_index           = CSR_CONFIRM_TIME;
      csr_write_data      = '0;
      reset               = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed walk with the timers at their reset value of zero
      send_idle_pct = 29;
      recv_idle_pct = 50;
      add_cmd(OP_TICK, 1'b0);        // inactive stays inactive
      add_cmd(OP_TICK, 1'b1);
      add_cmd(OP_UNUSED, 1'b1);      // unused opcode leaves state alone
      add_cmd(OP_START, 1'b0);       // sensor ignored on commands
      add_cmd(OP_TICK, 1'b1);
      add_cmd(OP_TICK, 1'b0);        // part seen, confirm
      add_cmd(OP_TICK, 1'b1);        // part gone, back to wait
      add_cmd(OP_TICK, 1'b0);
      add_cmd(OP_TICK, 1'b0);        // insert valve on
      add_cmd(OP_START, 1'b1);       // start keeps the insert valve on
      add_cmd(OP_TICK, 1'b0);
      add_cmd(OP_TICK, 1'b0);
      add_cmd(OP_TICK, 1'b1);        // insert off, sensor not looked at
      add_cmd(OP_TICK, 1'b1);        // press valve on
      add_cmd(OP_STOP, 1'b0);        // stop keeps the press valve on
      add_cmd(OP_UNUSED, 1'b0);
      add_cmd(OP_START, 1'b1);
      add_cmd(OP_TICK, 1'b0);
      add_cmd(OP_TICK, 1'b0);
      add_cmd(OP_TICK, 1'b0);
      add_cmd(OP_TICK, 1'b0);
      add_cmd(OP_TICK, 1'b0);        // press off, waiting for removal
      add_cmd(OP_TICK, 1'b0);
      add_cmd(OP_TICK, 1'b1);        // tube removed
      add_cmd(OP_TICK, 1'b0);        // hold-off done, rearmed
      wait_drained();

      program_timing(6);
      queue_part_cycles(450);
      wait_drained();

      // swap idling sides; long receiver stall while the sender keeps going
      send_idle_pct = 50;
      recv_idle_pct = 29;
      program_timing(4);
      queue_part_cycles(250);
      @(posedge clock);
      rsp_hold_cycles = LONG_HOLD;
      wait_drained();
      queue_part_cycles(250);
      wait_drained();

      // widest timers: a part held for a short while stays in confirm
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_csr(CSR_CONFIRM_TIME,    TIME_MAX);
      write_csr(CSR_INSERT_ON_TIME,  TIME_MAX);
      write_csr(CSR_INSERT_OFF_TIME, TIME_MAX);
      write_csr(CSR_PRESS_ON_TIME,   TIME_MAX);
      write_csr(CSR_HOLDOFF_TIME,    TIME_MAX);
      write_csr(CSR_SPARE_HI,        '0);
      add_cmd(OP_START, 1'b1);
      repeat (40) add_cmd(OP_TICK, 1'b0);
      add_cmd(OP_STOP, 1'b0);
      wait_drained();

      // all timers at zero, spare register written with ones
      write_csr(CSR_CONFIRM_TIME,    '0);
      write_csr(CSR_INSERT_ON_TIME,  '0);
      write_csr(CSR_INSERT_OFF_TIME, '0);
      write_csr(CSR_PRESS_ON_TIME,   '0);
      write_csr(CSR_HOLDOFF_TIME,    '0);
      write_csr(CSR_SPARE_LO,        TIME_MAX);
      queue_part_cycles(300);
      wait_drained();

      program_timing(12);
      queue_part_cycles(300);
      wait_drained();

      // catch any response that shows up late
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
